// ===== rtl/ordered_partner_table_top_macros.svh =====
// Assertion helpers used by the checker file opt_chk.sv.
`ifndef ORDERED_PARTNER_TABLE_TOP_MACROS_SVH
`define ORDERED_PARTNER_TABLE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, idle during rst.
`define OPT_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ordered partner table check failed");

// Next-cycle implication, sampled on clk, idle during rst.
`define OPT_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ordered partner table check failed");

`endif

// ===== rtl/opt_pkg.sv =====
`default_nettype none
package opt_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int RANK_BITS_DEF  = 16;
  localparam int VERTEX_BITS    = 16;
  localparam int RANK_PORT_BITS = 16;
  localparam int LEVEL_BITS     = 8;
  localparam int STATUS_BITS    = 2;

  typedef enum logic [1:0] {
    OP_ADD           = 2'd0,
    OP_REMOVE_VERTEX = 2'd1,
    OP_REMOVE_LEAST  = 2'd2,
    OP_QUERY         = 2'd3
  } op_t;

  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_SHIFT,
    S_SHIFT_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic shift_init;
    logic shift_rd;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic last_rd;
    logic shift_needed;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/ordered_partner_table_top.sv =====
// Channel  Signals                                             Transfer
// in       operation, vertex_id, entry_rank, entry_level        in_valid & in_ready
// out      status, entry_count, vertex_found, found_*, worst_*  out_valid & out_ready
//
// Empty table: no scan; the input transaction goes straight to the result.
// Otherwise the table memory is scanned one slot per cycle, then the result is decided.
// Remove-least of a non-last entry then shifts the later entries down to close the gap.
// One operation at a time; the next input transaction is taken while a result waits.
// Synchronous active-high rst empties the table; out stalls hold the finished operation.
`default_nettype none
module ordered_partner_table_top #(
  parameter int DEPTH     = opt_pkg::DEPTH_DEF,
  parameter int RANK_BITS = opt_pkg::RANK_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         operation,
  input  wire logic [opt_pkg::VERTEX_BITS-1:0]    vertex_id,
  input  wire logic [opt_pkg::RANK_PORT_BITS-1:0] entry_rank,
  input  wire logic [opt_pkg::LEVEL_BITS-1:0]     entry_level,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [opt_pkg::STATUS_BITS-1:0]         status,
  output logic [$clog2(DEPTH+1)-1:0]              entry_count,
  output logic                                    vertex_found,
  output logic [opt_pkg::RANK_PORT_BITS-1:0]      found_rank,
  output logic [opt_pkg::LEVEL_BITS-1:0]          found_level,
  output logic                                    worst_valid,
  output logic [opt_pkg::VERTEX_BITS-1:0]         worst_vertex,
  output logic [opt_pkg::RANK_PORT_BITS-1:0]      worst_rank,
  output logic [opt_pkg::LEVEL_BITS-1:0]          worst_level
);

  opt_pkg::cmd_t cmd;
  opt_pkg::sts_t sts;

  opt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  opt_dp #(
    .DEPTH     (DEPTH),
    .RANK_BITS (RANK_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .operation    (operation),
    .vertex_id    (vertex_id),
    .entry_rank   (entry_rank),
    .entry_level  (entry_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .entry_count  (entry_count),
    .vertex_found (vertex_found),
    .found_rank   (found_rank),
    .found_level  (found_level),
    .worst_valid  (worst_valid),
    .worst_vertex (worst_vertex),
    .worst_rank   (worst_rank),
    .worst_level  (worst_level)
  );

endmodule
`default_nettype wire

// ===== rtl/opt_ctrl.sv =====
`default_nettype none
module opt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire opt_pkg::sts_t sts,
  output opt_pkg::cmd_t      cmd
);

  opt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= opt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      opt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.empty ? opt_pkg::S_FINISH : opt_pkg::S_SCAN;
        end
      end
      opt_pkg::S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.last_rd) begin
          state_next = opt_pkg::S_DRAIN;
        end
      end
      opt_pkg::S_DRAIN: begin
        state_next = opt_pkg::S_DECIDE;
      end
      opt_pkg::S_DECIDE: begin
        if (sts.shift_needed) begin
          cmd.shift_init = 1'b1;
          state_next     = opt_pkg::S_SHIFT;
        end else begin
          state_next = opt_pkg::S_FINISH;
        end
      end
      opt_pkg::S_SHIFT: begin
        cmd.shift_rd = 1'b1;
        if (sts.last_rd) begin
          state_next = opt_pkg::S_SHIFT_DRAIN;
        end
      end
      opt_pkg::S_SHIFT_DRAIN: begin
        state_next = opt_pkg::S_FINISH;
      end
      opt_pkg::S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_next = opt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = opt_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/opt_dp.sv =====
`default_nettype none
module opt_dp #(
  parameter int DEPTH     = opt_pkg::DEPTH_DEF,
  parameter int RANK_BITS = opt_pkg::RANK_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire opt_pkg::cmd_t                      cmd,
  output opt_pkg::sts_t                           sts,
  input  wire logic [1:0]                         operation,
  input  wire logic [opt_pkg::VERTEX_BITS-1:0]    vertex_id,
  input  wire logic [opt_pkg::RANK_PORT_BITS-1:0] entry_rank,
  input  wire logic [opt_pkg::LEVEL_BITS-1:0]     entry_level,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [opt_pkg::STATUS_BITS-1:0]         status,
  output logic [$clog2(DEPTH+1)-1:0]              entry_count,
  output logic                                    vertex_found,
  output logic [opt_pkg::RANK_PORT_BITS-1:0]      found_rank,
  output logic [opt_pkg::LEVEL_BITS-1:0]          found_level,
  output logic                                    worst_valid,
  output logic [opt_pkg::VERTEX_BITS-1:0]         worst_vertex,
  output logic [opt_pkg::RANK_PORT_BITS-1:0]      worst_rank,
  output logic [opt_pkg::LEVEL_BITS-1:0]          worst_level
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [opt_pkg::VERTEX_BITS-1:0] vertex;
    logic [RANK_BITS-1:0]            rank;
    logic [opt_pkg::LEVEL_BITS-1:0]  level;
  } ent_t;

  ent_t mem [DEPTH];
  ent_t rdata;
  ent_t item;
  ent_t worst;
  ent_t wdata;

  opt_pkg::op_t op;

  logic [IW-1:0] ridx;
  logic [IW-1:0] pidx;
  logic [IW-1:0] worst_idx;
  logic [IW-1:0] waddr;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic [CW-1:0] wptr;

  logic pscan;
  logic pshift;
  logic worst_vld;
  logic found;
  logic [RANK_BITS-1:0]           frank;
  logic [opt_pkg::LEVEL_BITS-1:0] flevel;

  logic hit;
  logic less;
  logic take;
  logic we;
  logic [opt_pkg::STATUS_BITS-1:0] status_next;

  logic [31:0] rank_in_w;
  logic [31:0] frank_w;
  logic [31:0] wrank_w;

  assign rank_in_w = 32'(entry_rank);
  assign frank_w   = 32'(frank);
  assign wrank_w   = 32'(worst.rank);

  assign hit  = (rdata.vertex == item.vertex);
  assign less = (rdata.level < worst.level) ||
                ((rdata.level == worst.level) && (rdata.rank > worst.rank));
  assign take = !worst_vld || less;

  assign sts.empty        = (cnt == '0);
  assign sts.last_rd      = (CW'(ridx) == (cnt - CW'(1)));
  assign sts.shift_needed = (op == opt_pkg::OP_REMOVE_LEAST) &&
                            ((CW'(worst_idx) + CW'(1)) < cnt);
  assign sts.out_busy     = out_valid && !out_ready;

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    priority if (pscan && (op == opt_pkg::OP_REMOVE_VERTEX) && !hit) begin
      we    = 1'b1;
      waddr = wptr[IW-1:0];
    end else if (pshift) begin
      we    = 1'b1;
      waddr = pidx - IW'(1);
    end else if (cmd.commit && (op == opt_pkg::OP_ADD) && (cnt != CW'(DEPTH))) begin
      we    = 1'b1;
      waddr = cnt[IW-1:0];
      wdata = item;
    end
  end

  always_comb begin
    status_next = opt_pkg::ST_OK;
    cnt_next    = cnt;
    unique case (op)
      opt_pkg::OP_ADD: begin
        if (cnt == CW'(DEPTH)) begin
          status_next = opt_pkg::ST_FULL;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end
      opt_pkg::OP_REMOVE_VERTEX: begin
        if (cnt == '0) begin
          status_next = opt_pkg::ST_EMPTY;
        end else begin
          cnt_next = wptr;
        end
      end
      opt_pkg::OP_REMOVE_LEAST: begin
        if (cnt == '0) begin
          status_next = opt_pkg::ST_EMPTY;
        end else begin
          cnt_next = cnt - CW'(1);
        end
      end
      opt_pkg::OP_QUERY: begin
        cnt_next = cnt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd || cmd.shift_rd) begin
      rdata <= mem[ridx];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pscan     <= 1'b0;
      pshift    <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      pscan  <= cmd.scan_rd;
      pshift <= cmd.shift_rd;
      if (cmd.commit) begin
        out_valid <= 1'b1;
        cnt       <= cnt_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op          <= opt_pkg::op_t'(operation);
      item.vertex <= vertex_id;
      item.rank   <= rank_in_w[RANK_BITS-1:0];
      item.level  <= entry_level;
      ridx        <= '0;
      wptr        <= '0;
      worst_vld   <= 1'b0;
      worst       <= '0;
      worst_idx   <= '0;
      found       <= 1'b0;
      frank       <= '0;
      flevel      <= '0;
    end
    if (cmd.shift_init) begin
      ridx <= worst_idx + IW'(1);
    end
    if (cmd.scan_rd || cmd.shift_rd) begin
      pidx <= ridx;
      ridx <= ridx + IW'(1);
    end
    if (pscan) begin
      if (take) begin
        worst_vld <= 1'b1;
        worst     <= rdata;
        worst_idx <= pidx;
      end
      if ((op != opt_pkg::OP_ADD) && hit && !found) begin
        found  <= 1'b1;
        frank  <= rdata.rank;
        flevel <= rdata.level;
      end
      if ((op == opt_pkg::OP_REMOVE_VERTEX) && !hit) begin
        wptr <= wptr + CW'(1);
      end
    end
    if (cmd.commit) begin
      status       <= status_next;
      entry_count  <= cnt_next;
      vertex_found <= found;
      found_rank   <= frank_w[opt_pkg::RANK_PORT_BITS-1:0];
      found_level  <= flevel;
      worst_valid  <= worst_vld;
      worst_vertex <= worst.vertex;
      worst_rank   <= wrank_w[opt_pkg::RANK_PORT_BITS-1:0];
      worst_level  <= worst.level;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/opt_chk.sv =====
`default_nettype none
`include "ordered_partner_table_top_macros.svh"
module opt_chk #(
  parameter int DEPTH = opt_pkg::DEPTH_DEF
) (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [opt_pkg::STATUS_BITS-1:0]    status,
  input wire logic [$clog2(DEPTH+1)-1:0]         entry_count,
  input wire logic                               vertex_found,
  input wire logic                               worst_valid,
  input wire logic [opt_pkg::VERTEX_BITS-1:0]    worst_vertex
);

  logic full_out;
  logic empty_out;
  logic out_stall;

  assign full_out  = out_valid && (status == opt_pkg::ST_FULL);
  assign empty_out = out_valid && (status == opt_pkg::ST_EMPTY);
  assign out_stall = out_valid && !out_ready;

  `OPT_CHECK_NOW(a_count_range, out_valid, entry_count <= DEPTH)
  `OPT_CHECK_NOW(a_full_means_full, full_out, entry_count == DEPTH && worst_valid)
  `OPT_CHECK_NOW(a_empty_means_empty, empty_out, entry_count == 0 && !worst_valid && !vertex_found)
  `OPT_CHECK_NEXT(a_out_hold, out_stall, out_valid && $stable(entry_count) && $stable(worst_vertex))

endmodule

bind ordered_partner_table_top opt_chk #(.DEPTH(DEPTH)) u_opt_chk (.*);
`default_nettype wire
